### sv/keyed_lifo_value_store_unit_macros.svh
// ---------------------------------------------------------------------------
// keyed lifo value store assertion macros
// concurrent assertion helpers used by the store's top-level rtl file
// ---------------------------------------------------------------------------
`ifndef KEYED_LIFO_VALUE_STORE_UNIT_MACROS_SVH
`define KEYED_LIFO_VALUE_STORE_UNIT_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define KLVS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication
`define KLVS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define KLVS_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define KLVS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

### sv/klvs_pkg.sv
// ---------------------------------------------------------------------------
// klvs_pkg
// types and codes shared by the keyed lifo value store
// ---------------------------------------------------------------------------
package klvs_pkg;

    localparam int KEY_W = 8;
    localparam int VAL_W = 32;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_FETCH  = 2'd1,
        OP_CLEAR  = 2'd2,
        OP_NONE   = 2'd3
    } t_op;

    typedef struct packed {
        logic [VAL_W-1:0] val;
        logic [KEY_W-1:0] ky;
        logic [KEY_W-1:0] kx;
    } t_entry;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_READ = 6'b000010,
        S_CMP  = 6'b000100,
        S_SHR  = 6'b001000,
        S_SHW  = 6'b010000,
        S_DONE = 6'b100000
    } t_state;

endpackage

### sv/klvs_match.sv
// ---------------------------------------------------------------------------
// klvs_match
// shared key compare unit: checks one stored entry against the search key
// ---------------------------------------------------------------------------
module klvs_match (
    input  klvs_pkg::t_entry              i_entry,
    input  logic [klvs_pkg::KEY_W-1:0]    i_key_x,
    input  logic [klvs_pkg::KEY_W-1:0]    i_key_y,
    output logic                          o_hit
);

    assign o_hit = (i_entry.kx == i_key_x) && (i_entry.ky == i_key_y);

endmodule

### sv/keyed_lifo_value_store_unit.sv
// ---------------------------------------------------------------------------
// keyed_lifo_value_store_unit
// bounded newest-first store of 32-bit values keyed by (x, y)
// ---------------------------------------------------------------------------
// channel  | dir | tdata (low bit up)                | tuser
// s_axis   | in  | pos_x, pos_y, item_value (48 bits)| func (2 bits)
// m_axis   | out | result_value (32 bits)            | success (1 bit)
//
// insert, clear and unused codes go from accept straight to the done state.
// fetch walks the stack from the newest entry down through one memory read
// port and one key comparator, a read and a compare state per probed entry;
// on a hit, each newer entry moves down a slot in a read and a write state.
// the entry memory needs no clearing pass: a fill count marks the live entries.
// synchronous active-low reset empties the store; a stalled result waits in
// the output register while the next beat may already be accepted.
// ---------------------------------------------------------------------------
`include "keyed_lifo_value_store_unit_macros.svh"

module keyed_lifo_value_store_unit #(
    parameter int STORE_DEPTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // pos_x, pos_y, item_value
    input  logic [1:0]  s_axis_tuser,   // func
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // result_value
    output logic [0:0]  m_axis_tuser    // success
);

    localparam int CNT_W = $clog2(STORE_DEPTH + 1);
    localparam int AW    = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

    klvs_pkg::t_state r_state, n_state;
    logic [CNT_W-1:0] r_count, n_count;
    logic [AW-1:0]    r_idx, n_idx;
    logic [klvs_pkg::KEY_W-1:0] r_kx, n_kx, r_ky, n_ky;
    logic [klvs_pkg::VAL_W-1:0] r_res, n_res;
    logic             r_ok, n_ok;
    logic             r_out_valid, n_out_valid;
    logic [klvs_pkg::VAL_W-1:0] r_out_val, n_out_val;
    logic             r_out_ok, n_out_ok;

    klvs_pkg::t_entry mem [STORE_DEPTH];
    klvs_pkg::t_entry r_rd_data;

    logic             w_we;
    logic [AW-1:0]    w_waddr;
    klvs_pkg::t_entry w_wdata;

    logic             w_s_fire, w_m_fire, w_hit, w_top;
    logic [CNT_W-1:0] w_cnt_m1;
    klvs_pkg::t_entry w_in_entry;
    klvs_pkg::t_op    w_in_op;

    assign w_s_fire   = s_axis_tvalid && s_axis_tready;
    assign w_m_fire   = m_axis_tvalid && m_axis_tready;
    assign w_cnt_m1   = r_count - 1'b1;
    assign w_top      = (CNT_W'(r_idx) == w_cnt_m1);
    assign w_in_op    = klvs_pkg::t_op'(s_axis_tuser);
    assign w_in_entry = '{val: s_axis_tdata[47:16], ky: s_axis_tdata[15:8],
                          kx: s_axis_tdata[7:0]};

    klvs_match u_match (
        .i_entry (r_rd_data),
        .i_key_x (r_kx),
        .i_key_y (r_ky),
        .o_hit   (w_hit)
    );

    assign s_axis_tready = (r_state == klvs_pkg::S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_val;
    assign m_axis_tuser  = r_out_ok;

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_idx       = r_idx;
        n_kx        = r_kx;
        n_ky        = r_ky;
        n_res       = r_res;
        n_ok        = r_ok;
        n_out_valid = r_out_valid;
        n_out_val   = r_out_val;
        n_out_ok    = r_out_ok;
        w_we        = 1'b0;
        w_waddr     = r_idx;
        w_wdata     = r_rd_data;

        if (w_m_fire) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            klvs_pkg::S_IDLE: begin
                if (w_s_fire) begin
                    n_kx    = w_in_entry.kx;
                    n_ky    = w_in_entry.ky;
                    n_res   = '0;
                    n_ok    = 1'b0;
                    n_state = klvs_pkg::S_DONE;
                    case (w_in_op)
                        klvs_pkg::OP_INSERT: begin
                            if (r_count < CNT_W'(STORE_DEPTH)) begin
                                w_we    = 1'b1;
                                w_waddr = r_count[AW-1:0];
                                w_wdata = w_in_entry;
                                n_count = r_count + 1'b1;
                                n_res   = w_in_entry.val;
                                n_ok    = 1'b1;
                            end
                        end
                        klvs_pkg::OP_FETCH: begin
                            // search starts at the newest entry (top of stack)
                            if (r_count != '0) begin
                                n_idx   = w_cnt_m1[AW-1:0];
                                n_state = klvs_pkg::S_READ;
                            end
                        end
                        klvs_pkg::OP_CLEAR: begin
                            n_count = '0;
                            n_ok    = 1'b1;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            klvs_pkg::S_READ: begin
                n_state = klvs_pkg::S_CMP;
            end
            klvs_pkg::S_CMP: begin
                if (w_hit) begin
                    n_res = r_rd_data.val;
                    n_ok  = 1'b1;
                    if (w_top) begin
                        n_count = w_cnt_m1;
                        n_state = klvs_pkg::S_DONE;
                    end else begin
                        n_idx   = r_idx + 1'b1;
                        n_state = klvs_pkg::S_SHR;
                    end
                end else if (r_idx == '0) begin
                    n_state = klvs_pkg::S_DONE;
                end else begin
                    n_idx   = r_idx - 1'b1;
                    n_state = klvs_pkg::S_READ;
                end
            end
            klvs_pkg::S_SHR: begin
                n_state = klvs_pkg::S_SHW;
            end
            klvs_pkg::S_SHW: begin
                // move newer entry down one slot to close the gap
                w_we    = 1'b1;
                w_waddr = r_idx - 1'b1;
                w_wdata = r_rd_data;
                if (w_top) begin
                    n_count = w_cnt_m1;
                    n_state = klvs_pkg::S_DONE;
                end else begin
                    n_idx   = r_idx + 1'b1;
                    n_state = klvs_pkg::S_SHR;
                end
            end
            klvs_pkg::S_DONE: begin
                if (!r_out_valid || w_m_fire) begin
                    n_out_valid = 1'b1;
                    n_out_val   = r_res;
                    n_out_ok    = r_ok;
                    n_state     = klvs_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = klvs_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[w_waddr] <= w_wdata;
        end
        r_rd_data <= mem[r_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= klvs_pkg::S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx     <= n_idx;
        r_kx      <= n_kx;
        r_ky      <= n_ky;
        r_res     <= n_res;
        r_ok      <= n_ok;
        r_out_val <= n_out_val;
        r_out_ok  <= n_out_ok;
    end

    `KLVS_ASSERT_NOW(a_count_max, i_clk, i_rst_n, 1'b1, r_count <= CNT_W'(STORE_DEPTH))
    `KLVS_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, w_s_fire, !s_axis_tready)
    `KLVS_ASSERT_NEXT(a_clear_empties, i_clk, i_rst_n,
        w_s_fire && (w_in_op == klvs_pkg::OP_CLEAR), r_count == '0)
    `KLVS_ASSERT_NEXT(a_insert_grows, i_clk, i_rst_n,
        w_s_fire && (w_in_op == klvs_pkg::OP_INSERT) && (r_count < CNT_W'(STORE_DEPTH)),
        r_count == $past(r_count) + 1'b1)
    `KLVS_ASSERT_NOW(a_probe_in_range, i_clk, i_rst_n,
        (r_state == klvs_pkg::S_CMP) || (r_state == klvs_pkg::S_SHW),
        CNT_W'(r_idx) < r_count)

endmodule

### test/tb_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// stream-level test of the keyed newest-first value store: a queue-based model
// predicts every result beat, with directed corner cases, random insert, fetch,
// clear and unused-code traffic over small key pools and random stalls on both sides
// ---------------------------------------------------------------------------
module tb_top;

    localparam int DEPTH      = 16;
    localparam int IDLE_PCT   = 29;
    localparam int RAND_ITEMS = 1950;
    localparam int STALL_MAX  = 4000;
    localparam int DRAIN_WAIT = 4 * DEPTH + 40;

    typedef struct packed {
        logic [klvs_pkg::VAL_W-1:0] res_value;
        logic                       res_ok;
    } t_result;

    class lifo_scoreboard;
        klvs_pkg::t_entry live_q[$];      // index 0 is the newest entry
        t_result     pending_q[$];
        int unsigned fail_count;
        int unsigned insert_count;
        int unsigned reject_count;
        int unsigned hit_count;
        int unsigned miss_count;
        int unsigned clear_count;
        int unsigned unused_count;
        int unsigned max_fill;

        function void note_input(klvs_pkg::t_op op, logic [klvs_pkg::KEY_W-1:0] x,
                                 logic [klvs_pkg::KEY_W-1:0] y,
                                 logic [klvs_pkg::VAL_W-1:0] v);
            t_result          exp_r;
            klvs_pkg::t_entry e;
            int               hit;
            exp_r = '{res_value: '0, res_ok: 1'b0};
            case (op)
                klvs_pkg::OP_INSERT: begin
                    if (live_q.size() < DEPTH) begin
                        e.kx = x;
                        e.ky = y;
                        e.val = v;
                        live_q.push_front(e);
                        exp_r = '{res_value: v, res_ok: 1'b1};
                        insert_count++;
                    end else begin
                        reject_count++;
                    end
                end
                klvs_pkg::OP_FETCH: begin
                    hit = -1;
                    foreach (live_q[i]) begin
                        if (hit < 0 && live_q[i].kx == x && live_q[i].ky == y)
                            hit = i;
                    end
                    if (hit >= 0) begin
                        exp_r = '{res_value: live_q[hit].val, res_ok: 1'b1};
                        live_q.delete(hit);
                        hit_count++;
                    end else begin
                        miss_count++;
                    end
                end
                klvs_pkg::OP_CLEAR: begin
                    live_q.delete();
                    exp_r.res_ok = 1'b1;
                    clear_count++;
                end
                default: unused_count++;
            endcase
            if (live_q.size() > max_fill)
                max_fill = live_q.size();
            pending_q.push_back(exp_r);
        endfunction

        function void check_result(logic [klvs_pkg::VAL_W-1:0] act_value, logic act_ok);
            t_result exp_r;
            if (pending_q.size() == 0) begin
                $error("result beat with nothing expected: result_value %0h success %0b",
                       act_value, act_ok);
                fail_count++;
                return;
            end
            exp_r = pending_q.pop_front();
            if (act_value !== exp_r.res_value) begin
                $error("result_value: expected %0h, actual %0h", exp_r.res_value, act_value);
                fail_count++;
            end
            if (act_ok !== exp_r.res_ok) begin
                $error("success: expected %0b, actual %0b", exp_r.res_ok, act_ok);
                fail_count++;
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata = '0;     // pos_x, pos_y, item_value
    logic [1:0]  s_axis_tuser = '0;     // func
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;          // result_value
    logic [0:0]  m_axis_tuser;          // success

    lifo_scoreboard store_sb = new();
    logic        no_idle = 1'b0;
    int unsigned items_sent = 0;
    int unsigned stall_cycles = 0;

    keyed_lifo_value_store_unit #(.STORE_DEPTH(DEPTH)) DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // result side: random backpressure, none during the no-idle stretch
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
            if (m_axis_tvalid && m_axis_tready)
                store_sb.check_result(m_axis_tdata, m_axis_tuser[0]);
        end
    end

    // watchdog on cycles with no beat on either side
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_MAX) begin
            $display("keyed_lifo_value_store_unit: mismatch");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    task automatic send_op(klvs_pkg::t_op op, logic [klvs_pkg::KEY_W-1:0] x,
                           logic [klvs_pkg::KEY_W-1:0] y,
                           logic [klvs_pkg::VAL_W-1:0] v);
        while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {v, y, x};
        s_axis_tuser  <= op;
        do @(posedge i_clk); while (!s_axis_tready);
        store_sb.note_input(op, x, y, v);
        items_sent++;
    endtask

    task automatic wait_drained();
        while (store_sb.pending_q.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic run_directed();
        send_op(klvs_pkg::OP_CLEAR, 8'h00, 8'h00, 32'h0);
        send_op(klvs_pkg::OP_FETCH, 8'h00, 8'h00, 32'h0);
        send_op(klvs_pkg::OP_NONE, 8'hFF, 8'hFF, 32'hFFFF_FFFF);
        send_op(klvs_pkg::OP_INSERT, 8'h00, 8'h00, 32'h0);          // zero value still stored
        send_op(klvs_pkg::OP_INSERT, 8'hFF, 8'hFF, 32'hFFFF_FFFF);
        send_op(klvs_pkg::OP_INSERT, 8'h00, 8'h00, 32'h1);          // duplicate key
        for (int i = 1; i <= DEPTH - 3; i++)
            send_op(klvs_pkg::OP_INSERT, 8'(i), 8'(8'hFF - i), $urandom);
        send_op(klvs_pkg::OP_INSERT, 8'h12, 8'h34, 32'hA5A5_5A5A);  // store full
        send_op(klvs_pkg::OP_FETCH, 8'h00, 8'h00, 32'hFFFF_FFFF);   // newest duplicate
        send_op(klvs_pkg::OP_FETCH, 8'h00, 8'h00, 32'h0);           // oldest entry
        send_op(klvs_pkg::OP_FETCH, 8'h01, 8'h02, 32'h0);           // miss on full scan
        send_op(klvs_pkg::OP_CLEAR, 8'h5A, 8'hA5, 32'h0);
    endtask

    task automatic run_random();
        logic [klvs_pkg::KEY_W-1:0] pool_x[6];
        logic [klvs_pkg::KEY_W-1:0] pool_y[6];
        int                         insert_pct;
        int                         phase_len;
        int                         r;
        int                         k;
        logic [klvs_pkg::KEY_W-1:0] x;
        logic [klvs_pkg::KEY_W-1:0] y;
        logic [klvs_pkg::VAL_W-1:0] v;
        bit                         paused;
        paused = 0;
        while (items_sent < RAND_ITEMS) begin
            foreach (pool_x[i]) begin
                pool_x[i] = 8'($urandom_range(255));
                pool_y[i] = 8'($urandom_range(255));
            end
            // fill-heavy, drain-heavy or balanced phase
            case ($urandom_range(2))
                0: insert_pct = 70;
                1: insert_pct = 30;
                default: insert_pct = 50;
            endcase
            phase_len = $urandom_range(20, 60);
            for (int n = 0; n < phase_len; n++) begin
                no_idle = (items_sent >= 600 && items_sent < 900);
                if (!paused && items_sent >= 1100) begin
                    s_axis_tvalid <= 1'b0;
                    @(posedge i_clk);
                    wait_drained();
                    paused = 1;
                end
                k = $urandom_range(5);
                x = pool_x[k];
                y = pool_y[k];
                if ($urandom_range(9) == 0) begin
                    x = 8'($urandom_range(255));
                    y = 8'($urandom_range(255));
                end
                case ($urandom_range(9))
                    0: v = 32'h0;
                    1: v = 32'hFFFF_FFFF;
                    default: v = $urandom;
                endcase
                r = $urandom_range(99);
                if (r < 2)
                    send_op(klvs_pkg::OP_CLEAR, x, y, v);
                else if (r < 4)
                    send_op(klvs_pkg::OP_NONE, x, y, v);
                else if (r < 4 + insert_pct)
                    send_op(klvs_pkg::OP_INSERT, x, y, v);
                else
                    send_op(klvs_pkg::OP_FETCH, x, y, v);
            end
        end
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        run_directed();
        run_random();
        s_axis_tvalid <= 1'b0;
        no_idle = 1'b0;
        wait_drained();
        repeat (DRAIN_WAIT) @(posedge i_clk);
        $display("%0d ops: %0d inserts, %0d rejected as full, %0d fetch hits, %0d misses",
                 items_sent, store_sb.insert_count, store_sb.reject_count,
                 store_sb.hit_count, store_sb.miss_count);
        $display("%0d clears, %0d unused codes, peak fill %0d of %0d",
                 store_sb.clear_count, store_sb.unused_count, store_sb.max_fill, DEPTH);
        if (store_sb.fail_count == 0 && store_sb.pending_q.size() == 0) begin
            $display("keyed_lifo_value_store_unit: match");
        end else begin
            $display("keyed_lifo_value_store_unit: mismatch");
        end
        $finish;
    end

endmodule
